@@ rtl/mseu_pkg.sv @@
// Package for the MIPS subset execute unit: opcodes, datapath modes,
// store geometry and cycle-accounting constants.
// No dependencies.
package mseu_pkg;

	// Store geometry (DATA_WORDS is a power of two: the word index is a mask)
	localparam int DATA_WORDS = 1024;
	localparam int INST_BYTES = 2048;
	localparam int REG_COUNT  = 32;
	localparam int DATA_AW    = $clog2(DATA_WORDS);
	localparam int REG_AW     = $clog2(REG_COUNT);

	// Reset clear sweep covers both stores
	localparam int CLR_WORDS = (DATA_WORDS > REG_COUNT) ? DATA_WORDS : REG_COUNT;
	localparam int CLR_AW    = $clog2(CLR_WORDS);

	// Item field widths
	localparam int XLEN      = 32;
	localparam int OP_W      = 4;
	localparam int TARGET_W  = 11;
	localparam int PC_STEP   = 4;

	// Configuration port
	localparam int PADDR_W   = 3;
	localparam int PDATA_W   = 32;
	localparam logic REG_MODE_IDX = 1'b0;

	// Opcodes
	typedef enum logic [OP_W-1:0] {
		OP_ADD  = 4'd0,
		OP_SUB  = 4'd1,
		OP_ADDI = 4'd2,
		OP_SUBI = 4'd3,
		OP_OR   = 4'd4,
		OP_AND  = 4'd5,
		OP_SLL  = 4'd6,
		OP_SRL  = 4'd7,
		OP_LW   = 4'd8,
		OP_SW   = 4'd9,
		OP_J    = 4'd10,
		OP_BEQ  = 4'd11,
		OP_BNE  = 4'd12,
		OP_SLT  = 4'd13
	} op_t;

	// Datapath modes for cycle accounting
	typedef enum logic [1:0] {
		MODE_SINGLE = 2'd0,
		MODE_MULTI  = 2'd1,
		MODE_PIPE   = 2'd2,
		MODE_RSVD   = 2'd3
	} mode_t;

	// Cycle costs
	localparam logic [XLEN-1:0] CYC_ONE    = 32'd1;
	localparam logic [XLEN-1:0] CYC_BRANCH = 32'd3;
	localparam logic [XLEN-1:0] CYC_ALU    = 32'd4;
	localparam logic [XLEN-1:0] CYC_LOAD   = 32'd5;

endpackage

@@ rtl/mseu_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Read during write to the same address returns the old word.
// No dependencies.
module mseu_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/mips_subset_execute_unit.sv @@
// Top level of the MIPS subset execute unit: two-stage execute pipeline
// around a triple-ported (three copies) register file and a data store.
// Depends on mseu_pkg and mseu_ram.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+------------------------------------------
//   in      | input     | in_valid / in_ready   | op, dest_reg, src_reg, base_or_second_reg,
//           |           |                       | immediate, jump_target, target_known
//   out     | output    | out_valid / out_ready | next_pc, cycle_total, write_valid,
//           |           |                       | write_index, write_value, branch_taken
//   cfg     | input     | APB psel/penable      | datapath_mode at byte address 0
//
// Throughput is one item per cycle while the output is not stalled; an accepted item passes
// the register file read at accept, execute and data store access, then the output register.
// After reset both stores are swept to zero, one word a cycle, covering max(DATA_WORDS, 32)
// words (1024 here); in_ready stays low during the sweep, config writes are taken.
// A stalled output holds the second stage; the first stage and input keep filling
// until they meet it. Register hazards are covered by forwarding, with no bubbles.
module mips_subset_execute_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	// input items
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [3:0]                  op,
	input  logic [4:0]                  dest_reg,
	input  logic [4:0]                  src_reg,
	input  logic [4:0]                  base_or_second_reg,
	input  logic signed [31:0]          immediate,
	input  logic [10:0]                 jump_target,
	input  logic                        target_known,
	// result items
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [31:0]                 next_pc,
	output logic [31:0]                 cycle_total,
	output logic                        write_valid,
	output logic [4:0]                  write_index,
	output logic signed [31:0]          write_value,
	output logic                        branch_taken,
	// configuration
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [mseu_pkg::PADDR_W-1:0] paddr,
	input  logic [mseu_pkg::PDATA_W-1:0] pwdata,
	output logic [mseu_pkg::PDATA_W-1:0] prdata,
	output logic                        pready
);

	import mseu_pkg::*;

	// Clear sweep
	logic              clr_busy_q;
	logic [CLR_AW-1:0] clr_idx_q;

	// Architectural registers
	logic [XLEN-1:0] pc_q;
	logic [XLEN-1:0] cyc_q;
	mode_t           mode_q;

	// Stage 1: operands arrive from the register file
	logic                s1_valid_s1;
	op_t                 op_s1;
	logic [REG_AW-1:0]   rd_s1;
	logic [REG_AW-1:0]   rs_s1;
	logic [REG_AW-1:0]   rt_s1;
	logic [XLEN-1:0]     imm_s1;
	logic [TARGET_W-1:0] target_s1;
	logic                known_s1;

	// Stage 2: data store read returns, result assembled
	logic              s2_valid_s2;
	logic              wr_s2;
	logic              is_lw_s2;
	logic [REG_AW-1:0] rd_s2;
	logic [XLEN-1:0]   alu_s2;
	logic [XLEN-1:0]   pc_s2;
	logic [XLEN-1:0]   cyc_s2;
	logic              taken_s2;

	// Last committed register write, for forwarding
	logic              wb_valid_q;
	logic [REG_AW-1:0] wb_idx_q;
	logic [XLEN-1:0]   wb_data_q;

	// Output register
	logic              out_valid_q;
	logic [XLEN-1:0]   out_pc_q;
	logic [XLEN-1:0]   out_cyc_q;
	logic              out_wr_q;
	logic [REG_AW-1:0] out_idx_q;
	logic [XLEN-1:0]   out_value_q;
	logic              out_taken_q;

	// Flow control
	logic out_free, s2_adv, s2_stall, s1_move, in_fire;

	// RAM ports
	logic              rf_we;
	logic [REG_AW-1:0] rf_waddr;
	logic [XLEN-1:0]   rf_wdata;
	logic [XLEN-1:0]   rf_a_raw, rf_b_raw, rf_d_raw;
	logic              dm_we;
	logic [DATA_AW-1:0] dm_waddr, dm_addr;
	logic [XLEN-1:0]   dm_wdata;
	logic [XLEN-1:0]   dm_rdata;

	// Stage 1 datapath
	logic [XLEN-1:0] val_s2;
	logic [XLEN-1:0] opa, opb, opd;
	logic [XLEN-1:0] alu;
	logic [XLEN-1:0] mem_sum;
	logic            wr, jump_cond, is_lw, is_sw, usable, taken, op_defined;
	logic [XLEN-1:0] pc_next, cyc_next, multi_add, fill;

	// Handshake and stage movement
	assign out_free = !out_valid_q || out_ready;
	assign s2_adv   = s2_valid_s2 && out_free;
	assign s2_stall = s2_valid_s2 && !out_free;
	assign s1_move  = s1_valid_s1 && !s2_stall;
	assign in_ready = !clr_busy_q && !(s1_valid_s1 && s2_stall);
	assign in_fire  = in_valid && in_ready;

	// Register file: three copies, one per read operand, written alike
	assign rf_we    = clr_busy_q || (s2_adv && wr_s2);
	assign rf_waddr = clr_busy_q ? clr_idx_q[REG_AW-1:0] : rd_s2;
	assign rf_wdata = clr_busy_q ? '0 : val_s2;

	mseu_ram #(.WIDTH(XLEN), .DEPTH(REG_COUNT)) u_rf_a (
		.clk(clk), .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
		.re(in_fire), .raddr(src_reg), .rdata(rf_a_raw)
	);
	mseu_ram #(.WIDTH(XLEN), .DEPTH(REG_COUNT)) u_rf_b (
		.clk(clk), .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
		.re(in_fire), .raddr(base_or_second_reg), .rdata(rf_b_raw)
	);
	mseu_ram #(.WIDTH(XLEN), .DEPTH(REG_COUNT)) u_rf_d (
		.clk(clk), .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
		.re(in_fire), .raddr(dest_reg), .rdata(rf_d_raw)
	);

	// Data store: LW reads and SW writes happen as stage 1 moves on
	assign dm_we    = clr_busy_q || (s1_move && is_sw);
	assign dm_waddr = clr_busy_q ? clr_idx_q[DATA_AW-1:0] : dm_addr;
	assign dm_wdata = clr_busy_q ? '0 : opd;

	mseu_ram #(.WIDTH(XLEN), .DEPTH(DATA_WORDS)) u_dm (
		.clk(clk), .we(dm_we), .waddr(dm_waddr), .wdata(dm_wdata),
		.re(s1_move), .raddr(dm_addr), .rdata(dm_rdata)
	);

	// Value stage 2 commits
	assign val_s2 = is_lw_s2 ? dm_rdata : alu_s2;

	// Operand forwarding: stage 2 first, then the last committed write
	always_comb begin
		opa = rf_a_raw;
		opb = rf_b_raw;
		opd = rf_d_raw;
		if (wb_valid_q && wb_idx_q == rs_s1) opa = wb_data_q;
		if (wb_valid_q && wb_idx_q == rt_s1) opb = wb_data_q;
		if (wb_valid_q && wb_idx_q == rd_s1) opd = wb_data_q;
		if (s2_valid_s2 && wr_s2 && rd_s2 == rs_s1) opa = val_s2;
		if (s2_valid_s2 && wr_s2 && rd_s2 == rt_s1) opb = val_s2;
		if (s2_valid_s2 && wr_s2 && rd_s2 == rd_s1) opd = val_s2;
	end

	// Execute
	assign mem_sum = opb + imm_s1;
	assign dm_addr = mem_sum[DATA_AW-1:0];

	always_comb begin
		alu        = '0;
		wr         = 1'b0;
		jump_cond  = 1'b0;
		is_lw      = 1'b0;
		is_sw      = 1'b0;
		op_defined = 1'b1;
		multi_add  = CYC_ALU;
		fill       = CYC_ALU;
		case (op_s1)
			OP_ADD:  begin alu = opa + opb;  wr = 1'b1; end
			OP_SUB:  begin alu = opa - opb;  wr = 1'b1; end
			OP_ADDI: begin alu = opa + imm_s1; wr = 1'b1; end
			OP_SUBI: begin alu = opa - imm_s1; wr = 1'b1; end
			OP_OR:   begin alu = opa | opb;  wr = 1'b1; end
			OP_AND:  begin alu = opa & opb;  wr = 1'b1; end
			OP_SLL:  begin alu = opa << imm_s1[4:0]; wr = 1'b1; end
			OP_SRL:  begin alu = opa >> imm_s1[4:0]; wr = 1'b1; end
			OP_SLT:  begin
				alu = {{(XLEN-1){1'b0}}, ($signed(opa) < $signed(opb))};
				wr  = 1'b1;
			end
			OP_LW: begin
				wr        = 1'b1;
				is_lw     = 1'b1;
				multi_add = CYC_LOAD;
				fill      = CYC_LOAD;
			end
			OP_SW: begin
				alu   = opd;
				is_sw = 1'b1;
			end
			OP_J: begin
				jump_cond = 1'b1;
				multi_add = CYC_BRANCH;
				fill      = CYC_ONE;
			end
			OP_BEQ: begin
				jump_cond = (opd == opa);
				multi_add = CYC_BRANCH;
				fill      = CYC_BRANCH;
			end
			OP_BNE: begin
				jump_cond = (opd != opa);
				multi_add = CYC_BRANCH;
				fill      = CYC_BRANCH;
			end
			default: op_defined = 1'b0;
		endcase
	end

	// Branch target resolution and next PC
	assign usable  = known_s1 && (target_s1[1:0] == 2'b00) &&
		({{(XLEN-TARGET_W){1'b0}}, target_s1} < XLEN'(INST_BYTES));
	assign taken   = jump_cond && usable;
	assign pc_next = taken ? {{(XLEN-TARGET_W){1'b0}}, target_s1} : pc_q + XLEN'(PC_STEP);

	// Cycle accounting by mode
	always_comb begin
		cyc_next = cyc_q;
		if (op_defined) begin
			case (mode_q)
				MODE_MULTI: cyc_next = cyc_q + multi_add;
				MODE_PIPE:  cyc_next = (cyc_q == '0) ? fill : cyc_q + CYC_ONE;
				default:    cyc_next = cyc_q + CYC_ONE;
			endcase
		end
	end

	// Control state: sweep, valids, PC, counter, mode
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q  <= 1'b1;
			clr_idx_q   <= '0;
			s1_valid_s1 <= 1'b0;
			s2_valid_s2 <= 1'b0;
			out_valid_q <= 1'b0;
			wb_valid_q  <= 1'b0;
			pc_q        <= '0;
			cyc_q       <= '0;
			mode_q      <= MODE_SINGLE;
		end else begin
			if (clr_busy_q) begin
				clr_idx_q <= clr_idx_q + 1'b1;
				if (clr_idx_q == CLR_AW'(CLR_WORDS - 1)) clr_busy_q <= 1'b0;
			end
			if (in_fire)      s1_valid_s1 <= 1'b1;
			else if (s1_move) s1_valid_s1 <= 1'b0;
			if (s1_move)      s2_valid_s2 <= 1'b1;
			else if (s2_adv)  s2_valid_s2 <= 1'b0;
			if (s2_adv)         out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			if (s2_adv && wr_s2) wb_valid_q <= 1'b1;
			if (s1_move) begin
				pc_q  <= pc_next;
				cyc_q <= cyc_next;
			end
			if (psel && penable && pwrite && paddr[2] == REG_MODE_IDX) begin
				mode_q <= mode_t'(pwdata[1:0]);
			end
		end
	end

	// Stage 1 payload
	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_s1     <= op_t'(op);
			rd_s1     <= dest_reg;
			rs_s1     <= src_reg;
			rt_s1     <= base_or_second_reg;
			imm_s1    <= immediate;
			target_s1 <= jump_target;
			known_s1  <= target_known;
		end
	end

	// Stage 2 payload
	always_ff @(posedge clk) begin
		if (s1_move) begin
			wr_s2    <= wr;
			is_lw_s2 <= is_lw;
			rd_s2    <= rd_s1;
			alu_s2   <= alu;
			pc_s2    <= pc_next;
			cyc_s2   <= cyc_next;
			taken_s2 <= taken;
		end
	end

	// Forwarding copy of the last write and output payload
	always_ff @(posedge clk) begin
		if (s2_adv && wr_s2) begin
			wb_idx_q  <= rd_s2;
			wb_data_q <= val_s2;
		end
		if (s2_adv) begin
			out_pc_q    <= pc_s2;
			out_cyc_q   <= cyc_s2;
			out_wr_q    <= wr_s2;
			out_idx_q   <= wr_s2 ? rd_s2 : '0;
			out_value_q <= val_s2;
			out_taken_q <= taken_s2;
		end
	end

	// Ports
	assign out_valid    = out_valid_q;
	assign next_pc      = out_pc_q;
	assign cycle_total  = out_cyc_q;
	assign write_valid  = out_wr_q;
	assign write_index  = out_idx_q;
	assign write_value  = out_value_q;
	assign branch_taken = out_taken_q;
	assign pready       = 1'b1;
	assign prdata       = (paddr[2] == REG_MODE_IDX) ? {{(PDATA_W-2){1'b0}}, mode_q} : '0;

endmodule

@@ rtl/mseu_checker.sv @@
// Port-level checker for the MIPS subset execute unit, bound to the top level.
// Depends on mips_subset_execute_unit.
module mseu_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] next_pc,
	input logic        write_valid,
	input logic [4:0]  write_index,
	input logic        branch_taken
);

	// A waiting result item stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("out_valid dropped before accept");

	// A waiting result item keeps its PC
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(next_pc))
		else $error("next_pc changed while stalled");

	// No register write means index zero
	a_idx_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !write_valid |-> write_index == 5'd0)
		else $error("write_index set without a write");

	// A taken branch never writes a register and lands on an aligned low target
	a_taken: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && branch_taken |-> !write_valid && next_pc[1:0] == 2'b00 &&
		next_pc[31:11] == 21'd0)
		else $error("bad taken branch result");

endmodule

bind mips_subset_execute_unit mseu_checker u_mseu_checker (.*);

@@ tb/mseu_retire_checker.sv @@
`timescale 1ns / 1ps
// Result checker for the MIPS subset execute unit: keeps its own register file,
// data store, PC, cycle counter and mode, predicts every result and compares it.
// Depends on mseu_pkg.
module mseu_retire_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	// input channel
	input  logic                         in_valid,
	input  logic                         in_ready,
	input  logic [3:0]                   op,
	input  logic [4:0]                   dest_reg,
	input  logic [4:0]                   src_reg,
	input  logic [4:0]                   base_or_second_reg,
	input  logic [31:0]                  immediate,
	input  logic [10:0]                  jump_target,
	input  logic                         target_known,
	// output channel
	input  logic                         out_valid,
	input  logic                         out_ready,
	input  logic [31:0]                  next_pc,
	input  logic [31:0]                  cycle_total,
	input  logic                         write_valid,
	input  logic [4:0]                   write_index,
	input  logic [31:0]                  write_value,
	input  logic                         branch_taken,
	// config port
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [mseu_pkg::PADDR_W-1:0] paddr,
	input  logic [mseu_pkg::PDATA_W-1:0] pwdata,
	input  logic                         pready,
	// status for the testbench top
	output int                           mismatch_count,
	output int                           results_pending,
	output int                           instr_count,
	output int                           result_count,
	output int                           taken_count
);
	import mseu_pkg::*;

	typedef struct packed {
		logic [31:0] next_pc;
		logic [31:0] cycle_total;
		logic        write_valid;
		logic [4:0]  write_index;
		logic [31:0] write_value;
		logic        branch_taken;
	} retire_t;

	// Shadow architectural state
	logic [31:0] gpr [REG_COUNT];
	logic [31:0] dmem [DATA_WORDS];
	logic [31:0] pc_q;
	logic [31:0] cycles_q;
	mode_t       mode_q;

	retire_t expected_retires[$];

	// Cycle accounting per datapath mode; reserved mode counts as single-cycle
	function automatic void bump_cycles(input logic [31:0] multi_cost,
			input logic [31:0] fill_cost);
		case (mode_q)
			MODE_MULTI: cycles_q = cycles_q + multi_cost;
			MODE_PIPE:  cycles_q = (cycles_q == '0) ? fill_cost : cycles_q + CYC_ONE;
			default:    cycles_q = cycles_q + CYC_ONE;
		endcase
	endfunction

	// Execute one instruction against the shadow state and build its result
	task automatic execute_item(input logic [3:0] i_op, input logic [4:0] rd,
			input logic [4:0] rs, input logic [4:0] rt, input logic [31:0] imm,
			input logic [10:0] tgt, input logic known, output retire_t r);
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] value;
		logic [31:0] word_addr;
		logic        wr;
		logic        cond;
		logic        usable;
		logic        taken;
		a      = gpr[rs];
		b      = gpr[rt];
		value  = '0;
		wr     = 1'b0;
		cond   = 1'b0;
		// misaligned or out-of-range target acts like an unknown label
		usable = known && (tgt[1:0] == 2'b00) && (tgt < INST_BYTES);
		// base plus offset wraps at 2^32, then folds into the store
		word_addr = (b + imm) % DATA_WORDS;
		pc_q = pc_q + PC_STEP;
		case (i_op)
			OP_ADD: begin
				value = a + b; wr = 1'b1; bump_cycles(CYC_ALU, CYC_ALU);
			end
			OP_SUB: begin
				value = a - b; wr = 1'b1; bump_cycles(CYC_ALU, CYC_ALU);
			end
			OP_ADDI: begin
				value = a + imm; wr = 1'b1; bump_cycles(CYC_ALU, CYC_ALU);
			end
			OP_SUBI: begin
				value = a - imm; wr = 1'b1; bump_cycles(CYC_ALU, CYC_ALU);
			end
			OP_OR: begin
				value = a | b; wr = 1'b1; bump_cycles(CYC_ALU, CYC_ALU);
			end
			OP_AND: begin
				value = a & b; wr = 1'b1; bump_cycles(CYC_ALU, CYC_ALU);
			end
			OP_SLL: begin
				value = a << imm[4:0]; wr = 1'b1; bump_cycles(CYC_ALU, CYC_ALU);
			end
			OP_SRL: begin
				value = a >> imm[4:0]; wr = 1'b1; bump_cycles(CYC_ALU, CYC_ALU);
			end
			OP_LW: begin
				value = dmem[word_addr]; wr = 1'b1; bump_cycles(CYC_LOAD, CYC_LOAD);
			end
			OP_SW: begin
				value = gpr[rd];
				dmem[word_addr] = value;
				bump_cycles(CYC_ALU, CYC_ALU);
			end
			OP_J: begin
				cond = 1'b1; bump_cycles(CYC_BRANCH, CYC_ONE);
			end
			OP_BEQ: begin
				cond = (gpr[rd] == a); bump_cycles(CYC_BRANCH, CYC_BRANCH);
			end
			OP_BNE: begin
				cond = (gpr[rd] != a); bump_cycles(CYC_BRANCH, CYC_BRANCH);
			end
			OP_SLT: begin
				value = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
				wr = 1'b1;
				bump_cycles(CYC_ALU, CYC_ALU);
			end
			default: ;  // undefined opcode: PC step only
		endcase
		taken = cond && usable;
		if (taken) begin
			pc_q = 32'(tgt);
		end
		if (wr) begin
			gpr[rd] = value;
		end
		r.next_pc      = pc_q;
		r.cycle_total  = cycles_q;
		r.write_valid  = wr;
		r.write_index  = wr ? rd : '0;
		r.write_value  = value;
		r.branch_taken = taken;
	endtask

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%08h, got 0x%08h", name, want, got);
			mismatch_count++;
		end
	endfunction

	// Watch config, output and input channels at each edge
	always @(posedge clk or negedge arst_n) begin
		retire_t want;
		retire_t pred;
		if (!arst_n) begin
			for (int i = 0; i < REG_COUNT; i++) gpr[i] = '0;
			for (int i = 0; i < DATA_WORDS; i++) dmem[i] = '0;
			pc_q     = '0;
			cycles_q = '0;
			mode_q   = MODE_SINGLE;
			expected_retires.delete();
			mismatch_count  = 0;
			results_pending = 0;
			instr_count     = 0;
			result_count    = 0;
			taken_count     = 0;
		end else begin
			// register write; addresses past the mode register are ignored
			if (psel && penable && pwrite && pready && ((paddr >> 2) == REG_MODE_IDX)) begin
				mode_q = mode_t'(pwdata[1:0]);
			end
			if (out_valid && out_ready) begin
				result_count++;
				if (expected_retires.size() == 0) begin
					$error("result item with no instruction outstanding (next_pc 0x%08h)",
						next_pc);
					mismatch_count++;
				end else begin
					want = expected_retires.pop_front();
					check_field("next_pc", want.next_pc, next_pc);
					check_field("cycle_total", want.cycle_total, cycle_total);
					check_field("write_valid", 32'(want.write_valid), 32'(write_valid));
					check_field("write_index", 32'(want.write_index), 32'(write_index));
					check_field("write_value", want.write_value, write_value);
					check_field("branch_taken", 32'(want.branch_taken), 32'(branch_taken));
				end
			end
			if (in_valid && in_ready) begin
				execute_item(op, dest_reg, src_reg, base_or_second_reg, immediate,
					jump_target, target_known, pred);
				expected_retires.push_back(pred);
				instr_count++;
				if (pred.branch_taken) begin
					taken_count++;
				end
			end
			results_pending = expected_retires.size();
		end
	end

endmodule

@@ tb/mips_subset_execute_unit_tb.sv @@
`timescale 1ns / 1ps
// Testbench top for the MIPS subset execute unit: clock, reset, instruction and
// config stimulus, receiver stalls and verdict. Depends on mseu_pkg,
// mips_subset_execute_unit and mseu_retire_checker.
module mips_subset_execute_unit_tb;
	import mseu_pkg::*;

	localparam logic [3:0] OP_UNDEF_LO = 4'd14;
	localparam logic [3:0] OP_UNDEF_HI = 4'd15;
	localparam logic [PADDR_W-1:0] MODE_ADDR  = 3'd0;
	localparam logic [PADDR_W-1:0] SPARE_ADDR = 3'd4;  // no register behind it
	localparam int HOLD_CYCLES = 300;
	localparam int PHASE_ITEMS = 500;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [3:0]         op = '0;
	logic [4:0]         dest_reg = '0;
	logic [4:0]         src_reg = '0;
	logic [4:0]         base_or_second_reg = '0;
	logic signed [31:0] immediate = '0;
	logic [10:0]        jump_target = '0;
	logic               target_known = 1'b0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [31:0]        next_pc;
	logic [31:0]        cycle_total;
	logic               write_valid;
	logic [4:0]         write_index;
	logic signed [31:0] write_value;
	logic               branch_taken;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	int mismatch_count;
	int results_pending;
	int instr_count;
	int result_count;
	int taken_count;

	int tx_idle_pct = 0;
	int rx_stall_pct = 0;
	int hold_requests = 0;

	mips_subset_execute_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .op(op), .dest_reg(dest_reg),
		.src_reg(src_reg), .base_or_second_reg(base_or_second_reg),
		.immediate(immediate), .jump_target(jump_target), .target_known(target_known),
		.out_valid(out_valid), .out_ready(out_ready), .next_pc(next_pc),
		.cycle_total(cycle_total), .write_valid(write_valid), .write_index(write_index),
		.write_value(write_value), .branch_taken(branch_taken),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	mseu_retire_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .op(op), .dest_reg(dest_reg),
		.src_reg(src_reg), .base_or_second_reg(base_or_second_reg),
		.immediate(immediate), .jump_target(jump_target), .target_known(target_known),
		.out_valid(out_valid), .out_ready(out_ready), .next_pc(next_pc),
		.cycle_total(cycle_total), .write_valid(write_valid), .write_index(write_index),
		.write_value(write_value), .branch_taken(branch_taken),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .pready(pready),
		.mismatch_count(mismatch_count), .results_pending(results_pending),
		.instr_count(instr_count), .result_count(result_count),
		.taken_count(taken_count)
	);

	// 125 MHz clock
	initial begin
		forever #4 clk = ~clk;
	end

	// Hard stop in case the block hangs
	initial begin
		#4_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	// Receiver: random stalls, plus a long hold-off whenever one is requested
	initial begin
		int holds_served;
		holds_served = 0;
		forever begin
			@(posedge clk);
			if (hold_requests != holds_served) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				holds_served++;
			end
			out_ready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	// Offer one instruction item and return in the step it is accepted
	task automatic send_item(input logic [3:0] i_op, input logic [4:0] rd,
			input logic [4:0] rs, input logic [4:0] rt, input logic [31:0] imm,
			input logic [10:0] tgt, input logic known);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid           <= 1'b1;
		op                 <= i_op;
		dest_reg           <= rd;
		src_reg            <= rs;
		base_or_second_reg <= rt;
		immediate          <= imm;
		jump_target        <= tgt;
		target_known       <= known;
		@(posedge clk iff in_ready);
	endtask

	// Drop valid and wait until every predicted result has come back
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		wait (results_pending == 0);
	endtask

	// Setup cycle, then access cycle; pready is tied high
	task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Mix of full-range, small signed, extreme and in-store values
	function automatic logic [31:0] pick_imm();
		case ($urandom_range(3))
			0: return $urandom;
			1: return 32'(int'($urandom_range(32)) - 16);
			2: begin
				case ($urandom_range(3))
					0: return 32'h7FFF_FFFF;
					1: return 32'h8000_0000;
					2: return 32'h0000_0000;
					default: return 32'hFFFF_FFFF;
				endcase
			end
			default: return 32'($urandom_range(DATA_WORDS - 1));
		endcase
	endfunction

	// Mostly aligned targets, some with arbitrary low bits
	function automatic logic [10:0] pick_target();
		if ($urandom_range(3) != 0) begin
			return {9'($urandom_range(511)), 2'b00};
		end
		return 11'($urandom);
	endfunction

	// Main stimulus
	initial begin
		mode_t phase_mode [4];
		int    phase_tx [4];
		int    phase_rx [4];
		int    sent;
		int    pick;
		logic [4:0]  base_r;
		logic [4:0]  cmp_r;
		logic [31:0] imm_v;
		phase_mode = '{MODE_SINGLE, MODE_MULTI, MODE_PIPE, MODE_RSVD};
		phase_tx   = '{0, 76, 0, 21};
		phase_rx   = '{0, 0, 76, 21};

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// config during the clear sweep; the spare address must be ignored
		apb_write(SPARE_ADDR, 32'd1);
		apb_write(MODE_ADDR, 32'(MODE_PIPE));

		// Directed: undefined op first keeps the pipeline counter at zero,
		// so the next instruction shows the fill value
		send_item(OP_UNDEF_HI, 31, 31, 31, 32'hFFFF_FFFF, 11'h7FF, 1'b1);
		send_item(OP_ADDI, 1, 0, 0, 32'h7FFF_FFFF, 0, 1'b0);
		send_item(OP_ADDI, 2, 0, 0, 32'h8000_0000, 0, 1'b0);
		send_item(OP_ADD, 3, 1, 1, 0, 0, 1'b0);              // signed overflow wraps
		send_item(OP_SUB, 4, 2, 1, 0, 0, 1'b0);
		send_item(OP_SUBI, 5, 2, 0, 32'd1, 0, 1'b0);
		send_item(OP_OR, 6, 1, 2, 0, 0, 1'b0);
		send_item(OP_AND, 7, 6, 1, 0, 0, 1'b0);
		send_item(OP_SLL, 8, 6, 0, 32'hFFFF_FFE1, 0, 1'b0);  // only low 5 bits shift
		send_item(OP_SRL, 9, 2, 0, 32'h0000_003F, 0, 1'b0);  // logical, not arithmetic
		send_item(OP_SLT, 10, 2, 1, 0, 0, 1'b0);
		send_item(OP_SLT, 11, 1, 2, 0, 0, 1'b0);
		send_item(OP_SW, 6, 0, 2, 32'h8000_0005, 0, 1'b0);   // address wraps to word 5
		send_item(OP_LW, 12, 0, 0, 32'd5, 0, 1'b0);
		send_item(OP_LW, 13, 0, 1, 32'hFFFF_FFFF, 0, 1'b0);  // folds into the top words
		send_item(OP_J, 0, 0, 0, 0, 11'd2044, 1'b1);
		send_item(OP_J, 0, 0, 0, 0, 11'd2046, 1'b1);         // misaligned target
		send_item(OP_J, 0, 0, 0, 0, 11'd0, 1'b0);            // unknown label
		send_item(OP_BEQ, 3, 3, 0, 0, 11'd8, 1'b1);
		send_item(OP_BNE, 1, 2, 0, 0, 11'd16, 1'b1);
		send_item(OP_BNE, 1, 1, 0, 0, 11'd16, 1'b1);
		send_item(OP_BEQ, 1, 2, 0, 0, 11'd4, 1'b1);
		send_item(OP_ADD, 0, 1, 1, 0, 0, 1'b0);              // r0 is writable
		send_item(OP_UNDEF_LO, 0, 0, 0, 0, 0, 1'b0);
		send_item(OP_SW, 31, 0, 31, 32'h7FFF_FFFF, 11'h7FF, 1'b1);
		wait_drained();

		// Random phases, one per datapath mode
		for (int ph = 0; ph < 4; ph++) begin
			apb_write(MODE_ADDR, 32'(phase_mode[ph]));
			tx_idle_pct  = phase_tx[ph];
			rx_stall_pct = phase_rx[ph];
			// long receiver hold-off while the sender keeps pushing
			if (ph == 0) begin
				hold_requests++;
			end
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				pick = $urandom_range(99);
				if (pick < 20) begin
					// store then load from the same address
					base_r = 5'($urandom_range(31));
					imm_v  = pick_imm();
					send_item(OP_SW, 5'($urandom), 5'($urandom), base_r, imm_v,
						pick_target(), 1'($urandom));
					send_item(OP_LW, 5'($urandom), 5'($urandom), base_r, imm_v,
						pick_target(), 1'($urandom));
					sent += 2;
				end else if (pick < 27) begin
					// compare a register with itself
					cmp_r = 5'($urandom_range(31));
					send_item($urandom_range(1) ? 4'(OP_BEQ) : 4'(OP_BNE), cmp_r, cmp_r,
						5'($urandom), pick_imm(), pick_target(), 1'b1);
					sent++;
				end else begin
					// any opcode, undefined ones included
					send_item((pick < 32) ? 4'($urandom) : 4'($urandom_range(OP_SLT)),
						5'($urandom), 5'($urandom), 5'($urandom), pick_imm(),
						pick_target(), $urandom_range(3) != 0);
					sent++;
				end
			end
			wait_drained();
		end

		tx_idle_pct  = 0;
		rx_stall_pct = 0;
		repeat (16) @(posedge clk);

		$display("Ran %0d instructions over all opcodes and four datapath modes,",
			instr_count);
		$display("%0d results compared, %0d taken jumps or branches.",
			result_count, taken_count);
		if (mismatch_count == 0 && results_pending == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
